### design/ftvsp_pkg.sv
// Shared types and constants for the FIX tag=value stream parser.
package ftvsp_pkg;

  // Width of the tag field on the result channel
  localparam int unsigned TAG_OUT_W = 20;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEPARATOR    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_ENABLE = 2'd1;

  // Configuration reset values
  localparam logic [7:0] SEPARATOR_RESET    = 8'h01;
  localparam logic       CHECK_ENABLE_RESET = 1'b1;

  // Stream characters
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_EQUAL = 8'h3D;

  // Tag number of the checksum field
  localparam int unsigned CHECKSUM_TAG = 10;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_VALUE     = 3'd0,
    KIND_FIELD_END = 3'd1,
    KIND_MSG_OK    = 3'd2,
    KIND_CSUM_BAD  = 3'd3,
    KIND_MALFORMED = 3'd4
  } kind_e;

  // Parser phase
  typedef enum logic [1:0] {
    PH_TAG   = 2'd0,
    PH_VALUE = 2'd1,
    PH_SKIP  = 2'd2
  } phase_e;

  // One result item
  typedef struct packed {
    kind_e                kind;
    logic [TAG_OUT_W-1:0] tag;
    logic [7:0]           value_byte;
    logic [7:0]           computed_sum;
    logic [7:0]           received_sum;
  } result_t;

endpackage

### design/ftvsp_core.sv
// Per-byte parser state update and result generation.
module ftvsp_core #(
  parameter int unsigned TAG_BITS   = 20,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          data_byte_i,
  input  logic [7:0]          separator_i,
  input  logic                check_enable_i,
  output logic                res_valid_o,
  output ftvsp_pkg::result_t  res_o
);

  localparam logic [TAG_BITS-1:0]   TagMax  = '1;
  localparam logic [TAG_BITS-1:0]   ChkTag  = TAG_BITS'(ftvsp_pkg::CHECKSUM_TAG);
  localparam logic [COUNT_BITS-1:0] CountOne = COUNT_BITS'(1);

  ftvsp_pkg::phase_e phase_q, phase_d;
  logic [TAG_BITS-1:0]   tag_accum_q, tag_accum_d;
  logic                  tag_digits_q, tag_digits_d;
  logic [7:0]            tag_sum_q, tag_sum_d;
  logic [7:0]            running_sum_q, running_sum_d;
  logic [7:0]            received_accum_q, received_accum_d;
  logic [COUNT_BITS-1:0] message_count_q, message_count_d;
  logic [COUNT_BITS-1:0] csum_err_count_q, csum_err_count_d;
  logic [COUNT_BITS-1:0] parse_err_count_q, parse_err_count_d;

  logic                  is_sep, is_digit, is_equal, is_chk;
  logic [3:0]            digit;
  logic [TAG_BITS+3:0]   tag_wide, tag_mul;
  logic [TAG_BITS-1:0]   tag_sat;
  logic [7:0]            recv_mul;
  logic [ftvsp_pkg::TAG_OUT_W-1:0] tag_out;

  // Classify the incoming byte
  assign is_sep   = (data_byte_i == separator_i);
  assign is_digit = (data_byte_i >= ftvsp_pkg::CHAR_ZERO) &&
                    (data_byte_i <= ftvsp_pkg::CHAR_NINE);
  assign is_equal = (data_byte_i == ftvsp_pkg::CHAR_EQUAL);
  assign digit    = 4'(data_byte_i - ftvsp_pkg::CHAR_ZERO);
  assign is_chk   = tag_digits_q && (tag_accum_q == ChkTag);

  // Decimal accumulate with saturation for the tag, wrap for the checksum
  assign tag_wide = {4'b0, tag_accum_q};
  assign tag_mul  = (tag_wide << 3) + (tag_wide << 1) + {{TAG_BITS{1'b0}}, digit};
  assign tag_sat  = (tag_mul > {4'b0, TagMax}) ? TagMax : tag_mul[TAG_BITS-1:0];
  assign recv_mul = (received_accum_q << 3) + (received_accum_q << 1) + {4'b0, digit};

  // Fit the tag to the result field
  if (TAG_BITS >= ftvsp_pkg::TAG_OUT_W) begin : g_tag_trunc
    assign tag_out = tag_accum_q[ftvsp_pkg::TAG_OUT_W-1:0];
  end else begin : g_tag_ext
    assign tag_out = {{(ftvsp_pkg::TAG_OUT_W - TAG_BITS){1'b0}}, tag_accum_q};
  end

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (accept_i) begin
      case (phase_q)
        ftvsp_pkg::PH_VALUE: begin
          if (is_sep) phase_d = ftvsp_pkg::PH_TAG;
        end
        ftvsp_pkg::PH_SKIP: begin
          if (is_sep) phase_d = ftvsp_pkg::PH_TAG;
        end
        ftvsp_pkg::PH_TAG: begin
          if (is_sep || is_digit) phase_d = ftvsp_pkg::PH_TAG;
          else if (is_equal && tag_digits_q) phase_d = ftvsp_pkg::PH_VALUE;
          else phase_d = ftvsp_pkg::PH_SKIP;
        end
        default: phase_d = ftvsp_pkg::PH_TAG;
      endcase
    end
  end

  // Datapath update and result
  always_comb begin
    tag_accum_d       = tag_accum_q;
    tag_digits_d      = tag_digits_q;
    tag_sum_d         = tag_sum_q;
    running_sum_d     = running_sum_q;
    received_accum_d  = received_accum_q;
    message_count_d   = message_count_q;
    csum_err_count_d  = csum_err_count_q;
    parse_err_count_d = parse_err_count_q;
    res_valid_o       = 1'b0;
    res_o.kind        = ftvsp_pkg::KIND_VALUE;
    res_o.tag         = tag_out;
    res_o.value_byte  = 8'd0;
    res_o.computed_sum = 8'd0;
    res_o.received_sum = 8'd0;

    if (accept_i) begin
      case (phase_q)
        ftvsp_pkg::PH_VALUE: begin
          if (is_chk) begin
            if (is_sep) begin
              // end of message: compare and clear the sums
              res_valid_o        = 1'b1;
              res_o.computed_sum = running_sum_q;
              res_o.received_sum = received_accum_q;
              if (!check_enable_i || (running_sum_q == received_accum_q)) begin
                res_o.kind      = ftvsp_pkg::KIND_MSG_OK;
                message_count_d = message_count_q + CountOne;
              end else begin
                res_o.kind        = ftvsp_pkg::KIND_CSUM_BAD;
                csum_err_count_d  = csum_err_count_q + CountOne;
                parse_err_count_d = parse_err_count_q + CountOne;
              end
              running_sum_d    = 8'd0;
              received_accum_d = 8'd0;
              tag_accum_d      = '0;
              tag_digits_d     = 1'b0;
              tag_sum_d        = 8'd0;
            end else begin
              if (is_digit) received_accum_d = recv_mul;
              res_valid_o        = 1'b1;
              res_o.value_byte   = data_byte_i;
              res_o.computed_sum = running_sum_q;
              res_o.received_sum = received_accum_d;
            end
          end else begin
            running_sum_d      = running_sum_q + data_byte_i;
            res_valid_o        = 1'b1;
            res_o.computed_sum = running_sum_d;
            res_o.received_sum = received_accum_q;
            if (is_sep) begin
              res_o.kind   = ftvsp_pkg::KIND_FIELD_END;
              tag_accum_d  = '0;
              tag_digits_d = 1'b0;
              tag_sum_d    = 8'd0;
            end else begin
              res_o.value_byte = data_byte_i;
            end
          end
        end
        ftvsp_pkg::PH_SKIP: begin
          running_sum_d = running_sum_q + data_byte_i;
          if (is_sep) begin
            tag_accum_d  = '0;
            tag_digits_d = 1'b0;
            tag_sum_d    = 8'd0;
          end
        end
        ftvsp_pkg::PH_TAG: begin
          if (is_sep) begin
            // separator before any '=': malformed, start a new tag
            running_sum_d      = running_sum_q + tag_sum_q + data_byte_i;
            parse_err_count_d  = parse_err_count_q + CountOne;
            res_valid_o        = 1'b1;
            res_o.kind         = ftvsp_pkg::KIND_MALFORMED;
            res_o.computed_sum = running_sum_d;
            res_o.received_sum = received_accum_q;
            tag_accum_d        = '0;
            tag_digits_d       = 1'b0;
            tag_sum_d          = 8'd0;
          end else if (is_digit) begin
            tag_accum_d  = tag_sat;
            tag_digits_d = 1'b1;
            tag_sum_d    = tag_sum_q + data_byte_i;
          end else if (is_equal && tag_digits_q) begin
            // checksum tag bytes stay out of the sum
            if (!is_chk) running_sum_d = running_sum_q + tag_sum_q + data_byte_i;
            tag_sum_d = 8'd0;
          end else begin
            // bad tag byte or empty tag: flag and skip the field
            running_sum_d      = running_sum_q + tag_sum_q + data_byte_i;
            tag_sum_d          = 8'd0;
            parse_err_count_d  = parse_err_count_q + CountOne;
            res_valid_o        = 1'b1;
            res_o.kind         = ftvsp_pkg::KIND_MALFORMED;
            res_o.computed_sum = running_sum_d;
            res_o.received_sum = received_accum_q;
          end
        end
        default: begin
          tag_accum_d  = '0;
          tag_digits_d = 1'b0;
          tag_sum_d    = 8'd0;
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q           <= ftvsp_pkg::PH_TAG;
      tag_accum_q       <= '0;
      tag_digits_q      <= 1'b0;
      tag_sum_q         <= 8'd0;
      running_sum_q     <= 8'd0;
      received_accum_q  <= 8'd0;
      message_count_q   <= '0;
      csum_err_count_q  <= '0;
      parse_err_count_q <= '0;
    end else begin
      phase_q           <= phase_d;
      tag_accum_q       <= tag_accum_d;
      tag_digits_q      <= tag_digits_d;
      tag_sum_q         <= tag_sum_d;
      running_sum_q     <= running_sum_d;
      received_accum_q  <= received_accum_d;
      message_count_q   <= message_count_d;
      csum_err_count_q  <= csum_err_count_d;
      parse_err_count_q <= parse_err_count_d;
    end
  end

endmodule

### design/ftvsp_out_buf.sv
// Result register with a skid stage for the output channel.
module ftvsp_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               res_valid_i,
  input  ftvsp_pkg::result_t res_i,
  input  logic               out_stall_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  output ftvsp_pkg::result_t out_o
);

  logic               out_valid_q, out_valid_d;
  logic               skid_valid_q, skid_valid_d;
  ftvsp_pkg::result_t out_q, out_d;
  ftvsp_pkg::result_t skid_q, skid_d;
  logic               out_busy;

  assign out_busy = out_valid_q && out_stall_i;

  // Hold, refill from skid, or load a new result
  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (out_busy) begin
      if (res_valid_i) begin
        skid_valid_d = 1'b1;
        skid_d       = res_i;
      end
    end else if (skid_valid_q) begin
      out_valid_d  = 1'b1;
      out_d        = skid_q;
      skid_valid_d = 1'b0;
    end else begin
      out_valid_d = res_valid_i;
      out_d       = res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

### design/fix_tag_value_stream_parser_unit.sv
// Top level of the FIX tag=value stream parser with checksum check.
//
// Input channel: one raw stream byte per request on data_byte_i, qualified
// by in_valid_i and taken when in_stall_o is low. Output channel: at most
// one result per byte (kind, tag, value byte, computed and received sums),
// qualified by out_valid_o and taken when out_stall_i is low. Bytes that
// only advance the tag or are skipped give no result.
// Configuration: cfg_index_i selects the separator (0) or the checksum
// enable (1); a write completes on cfg_valid_i with cfg_ready_o, which is
// always high. Other indexes are ignored.
// Results are registered in the result register, or in the skid stage on a
// stall. Throughput: one byte per cycle while in_stall_o is low; the whole
// per-byte update is logic between the parser state and the result register.
// Stall: a stalled result holds; one more result fits in the skid stage,
// after which in_stall_o rises until the stalled result is taken.
// Reset: asynchronous; parser starts in the tag phase with all sums and
// counters cleared, separator 0x01 and checking enabled.
module fix_tag_value_stream_parser_unit #(
  parameter int unsigned TAG_BITS   = 20,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [7:0]                          data_byte_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [2:0]                          kind_o,
  output logic [ftvsp_pkg::TAG_OUT_W-1:0]     tag_o,
  output logic [7:0]                          value_byte_o,
  output logic [7:0]                          computed_sum_o,
  output logic [7:0]                          received_sum_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ftvsp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [7:0]                          cfg_data_i
);

  logic [7:0]         sep_q;
  logic               check_enable_q;
  logic               accept;
  logic               res_valid;
  ftvsp_pkg::result_t res;
  ftvsp_pkg::result_t out_res;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && !in_stall_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q          <= ftvsp_pkg::SEPARATOR_RESET;
      check_enable_q <= ftvsp_pkg::CHECK_ENABLE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        ftvsp_pkg::CFG_SEPARATOR:    sep_q          <= cfg_data_i;
        ftvsp_pkg::CFG_CHECK_ENABLE: check_enable_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  ftvsp_core #(
    .TAG_BITS   (TAG_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .data_byte_i    (data_byte_i),
    .separator_i    (sep_q),
    .check_enable_i (check_enable_q),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  ftvsp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_stall_i (out_stall_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_o       (out_res)
  );

  assign kind_o         = out_res.kind;
  assign tag_o          = out_res.tag;
  assign value_byte_o   = out_res.value_byte;
  assign computed_sum_o = out_res.computed_sum;
  assign received_sum_o = out_res.received_sum;

endmodule

### design/ftvsp_checker.sv
// Port-level checks for the FIX stream parser, bound to the top level.
module ftvsp_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [2:0]                      kind_o,
  input logic [ftvsp_pkg::TAG_OUT_W-1:0] tag_o,
  input logic [7:0]                      value_byte_o,
  input logic [7:0]                      computed_sum_o,
  input logic [7:0]                      received_sum_o
);

  // A stalled result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) && $stable(tag_o)
      && $stable(value_byte_o) && $stable(computed_sum_o) && $stable(received_sum_o))
    else $error("stalled result changed");

  // Only value results carry a byte
  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != ftvsp_pkg::KIND_VALUE) |-> value_byte_o == 8'd0)
    else $error("non-value result carries a byte");

  // Message end comes only from the checksum field
  a_end_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((kind_o == ftvsp_pkg::KIND_MSG_OK) ||
                    (kind_o == ftvsp_pkg::KIND_CSUM_BAD))
      |-> tag_o == ftvsp_pkg::TAG_OUT_W'(ftvsp_pkg::CHECKSUM_TAG))
    else $error("message end with a tag other than the checksum tag");

  // A mismatch means the sums really differ
  a_mismatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == ftvsp_pkg::KIND_CSUM_BAD)
      |-> computed_sum_o != received_sum_o)
    else $error("checksum mismatch reported with equal sums");

endmodule

bind fix_tag_value_stream_parser_unit ftvsp_checker u_ftvsp_checker (.*);
